// ===== hdl/qualified_period_to_frequency_macros.svh =====
// assertion macros used by the asserting module
`ifndef QUALIFIED_PERIOD_TO_FREQUENCY_MACROS_SVH
`define QUALIFIED_PERIOD_TO_FREQUENCY_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define QPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpf check failed");

// next-cycle implication, sampled on clk, off while in reset
`define QPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpf check failed");

`endif

// ===== hdl/qpf_pkg.sv =====
`default_nettype none

package qpf_pkg;

    // field widths
    localparam int PERIOD_W = 16;
    localparam int SUM_W    = 18;
    localparam int REF_W    = 26;
    localparam int HUND_W   = 17;
    localparam int REM_W    = 7;

    // reset value of the reference clock register
    localparam logic [REF_W-1:0] REF_RESET_HZ = 26'd48000000;

    // divisor used to split the frequency into hundreds and remainder
    localparam int FREQ_SPLIT = 100;

    // periods per acquisition, counted 0..3
    localparam logic [1:0] LAST_COUNT = 2'd3;

    // shared divider: one quotient bit per cycle
    localparam int DIV_STEPS = REF_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // divider request from the sequencer
    typedef struct packed {
        logic               start;
        logic [REF_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_REF,
        ST_DIV_HUND,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/qpf_div.sv =====
`default_nettype none

module qpf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qpf_pkg::div_req_t             req,
    output qpf_pkg::div_status_t          status,
    output logic [qpf_pkg::REF_W-1:0]     quotient,
    output logic [qpf_pkg::PERIOD_W-1:0]  remainder
);
    import qpf_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [REF_W-1:0]    work_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] divisor_reg;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   trial_diff;
    logic                fits;
    logic [PERIOD_W-1:0] rem_next;
    logic [REF_W-1:0]    work_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial      = {rem_reg, work_reg[REF_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = (trial >= {1'b0, divisor_reg});
        rem_next   = fits ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        work_next  = {work_reg[REF_W-2:0], fits};
    end

    // step counter and handshake with the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/qualified_period_to_frequency.sv =====
// a period that does not complete an acquisition is taken while the block stays idle
// the fourth qualified period starts two divider passes; the reading then waits for a free output
// one period per cycle while idle; the input is stalled from each fourth qualified period until
// its reading is loaded; the busy time is set by the shared restoring divider and the output stall
// reset: asynchronous, active low; clears the acquisition and the output valid,
// and loads the reference clock register with 48000000
`default_nettype none

`include "qualified_period_to_frequency_macros.svh"

module qualified_period_to_frequency (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qpf_pkg::REF_W-1:0]     reference_clock_hz,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [qpf_pkg::PERIOD_W-1:0]  period_ticks,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [qpf_pkg::HUND_W-1:0]    frequency_hundreds,
    output logic [qpf_pkg::REM_W-1:0]     frequency_remainder,
    output logic [qpf_pkg::PERIOD_W-1:0]  average_period
);
    import qpf_pkg::*;

    state_t              state_reg;
    state_t              state_next;

    logic [REF_W-1:0]    ref_clk_reg;
    logic [1:0]          accepted_count_reg;
    logic [PERIOD_W-1:0] previous_period_reg;
    logic [SUM_W-1:0]    period_sum_reg;
    logic [PERIOD_W-1:0] avg_reg;

    logic                out_valid_reg;
    logic [HUND_W-1:0]   frequency_hundreds_reg;
    logic [REM_W-1:0]    frequency_remainder_reg;
    logic [PERIOD_W-1:0] average_period_reg;

    logic                in_fire;
    logic                out_free;
    logic                out_load;
    logic [PERIOD_W-1:0] diff;
    logic [PERIOD_W:0]   diff_p1;
    logic [PERIOD_W+4:0] diff_x10;
    logic                close;
    logic                fourth;
    logic [SUM_W-1:0]    sum_plus;
    logic [PERIOD_W-1:0] avg_next;

    div_req_t            div_req;
    div_status_t         div_status;
    logic [REF_W-1:0]    div_quotient;
    logic [PERIOD_W-1:0] div_remainder;

    // shared divider, used for reference / average and then for the split by 100
    qpf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_OUT) && out_free;

    // qualification: |p - prev| < prev/10 is the same as 10*(|p - prev| + 1) <= prev
    always_comb
    begin
        diff     = (period_ticks > previous_period_reg) ?
                   (period_ticks - previous_period_reg) :
                   (previous_period_reg - period_ticks);
        diff_p1  = {1'b0, diff} + 1'b1;
        diff_x10 = {1'b0, diff_p1, 3'b000} + {3'b000, diff_p1, 1'b0};
        close    = (diff_x10 <= {5'b00000, previous_period_reg});
        fourth   = (accepted_count_reg == LAST_COUNT) && close;
        sum_plus = period_sum_reg + {2'b00, period_ticks};
        avg_next = sum_plus[SUM_W-1:2];
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and divider requests
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = ref_clk_reg;
        div_req.divisor  = avg_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && fourth)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_REF;
                end
            end
            ST_DIV_REF:
            begin
                // a zero average gives a zero frequency
                div_req.dividend = (avg_reg == '0) ? '0 : div_quotient;
                div_req.divisor  = PERIOD_W'(FREQ_SPLIT);
                if (div_status.done)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_HUND;
                end
            end
            ST_DIV_HUND:
            begin
                div_req.divisor = PERIOD_W'(FREQ_SPLIT);
                if (div_status.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                div_req.divisor = PERIOD_W'(FREQ_SPLIT);
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reference clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clk_reg <= REF_RESET_HZ;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ref_clk_reg <= reference_clock_hz;
        end
    end

    // acquisition of four qualified periods
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_count_reg  <= '0;
            previous_period_reg <= '0;
            period_sum_reg      <= '0;
        end
        else if (in_fire)
        begin
            if (accepted_count_reg == '0)
            begin
                previous_period_reg <= period_ticks;
                period_sum_reg      <= {2'b00, period_ticks};
                accepted_count_reg  <= 2'd1;
            end
            else if (!close)
            begin
                accepted_count_reg <= '0;
            end
            else
            begin
                previous_period_reg <= period_ticks;
                period_sum_reg      <= sum_plus;
                accepted_count_reg  <= fourth ? 2'd0 : accepted_count_reg + 1'b1;
            end
        end
    end

    // average of the completed acquisition
    always_ff @(posedge clk)
    begin
        if (in_fire && fourth)
        begin
            avg_reg <= avg_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frequency_hundreds_reg  <= div_quotient[HUND_W-1:0];
            frequency_remainder_reg <= div_remainder[REM_W-1:0];
            average_period_reg      <= avg_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign frequency_hundreds  = frequency_hundreds_reg;
    assign frequency_remainder = frequency_remainder_reg;
    assign average_period      = average_period_reg;

    // divider finishes only while the sequencer waits for it
    `QPF_ASSERT_NOW(a_done_in_div, div_status.done,
        (state_reg == ST_DIV_REF) || (state_reg == ST_DIV_HUND))
    // a completed acquisition starts the first division
    `QPF_ASSERT_NEXT(a_fourth_starts, in_fire && fourth,
        (state_reg == ST_DIV_REF) && div_status.busy)
    // remainder of the split by 100 fits below 100 when loaded
    `QPF_ASSERT_NOW(a_rem_range, out_load,
        div_remainder < PERIOD_W'(FREQ_SPLIT))
    // a qualified average is never below ten
    `QPF_ASSERT_NOW(a_avg_range, out_valid_reg,
        average_period_reg >= PERIOD_W'(10))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpf_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned SETTLE_CYCLES    = 64;
    localparam int unsigned RANDOM_PER_PHASE = 140;
    localparam int unsigned HOLD_CYCLES      = 500;

    // receiver stall patterns
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_LIGHT,
        PACE_HEAVY,
        PACE_PERIODIC
    } pace_t;

    // one frequency reading as the block reports it
    typedef struct packed {
        logic [HUND_W-1:0]   hundreds;
        logic [REM_W-1:0]    remainder;
        logic [PERIOD_W-1:0] avg;
    } freq_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REF_W-1:0]     cfg_ref_hz = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PERIOD_W-1:0]  period_ticks = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [HUND_W-1:0]    frequency_hundreds;
    logic [REM_W-1:0]     frequency_remainder;
    logic [PERIOD_W-1:0]  average_period;

    qualified_period_to_frequency dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .reference_clock_hz  (cfg_ref_hz),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .period_ticks        (period_ticks),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .frequency_hundreds  (frequency_hundreds),
        .frequency_remainder (frequency_remainder),
        .average_period      (average_period)
    );

    // predictor state
    logic [REF_W-1:0]    ref_hz_now = REF_RESET_HZ;
    logic [1:0]          acq_count = '0;
    logic [PERIOD_W-1:0] last_period = '0;
    logic [SUM_W-1:0]    sum_acc = '0;

    logic [PERIOD_W-1:0] period_backlog[$];
    freq_result_t        freq_due[$];
    freq_result_t        fresh_result;
    freq_result_t        oldest_due;

    int unsigned cyc = 0;
    int unsigned mismatches = 0;
    int unsigned taken_total = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 200;
    int unsigned pace_left = 0;
    pace_t       pace = PACE_FREE;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cyc, what);
        mismatches++;
    endtask

    // advance the acquisition by one period; returns 1 when a reading is due
    function automatic bit qualify_period(input logic [PERIOD_W-1:0] p,
                                          output freq_result_t r);
        logic [PERIOD_W-1:0] tenth;
        logic [PERIOD_W-1:0] diff;
        logic [PERIOD_W-1:0] avg_p;
        logic [REF_W-1:0]    quot;
        r = '0;
        tenth = PERIOD_W'(last_period / 10);
        diff = (last_period > p) ? last_period - p : p - last_period;
        if (acq_count == 2'd0)
        begin
            last_period = p;
            sum_acc = SUM_W'(p);
            acq_count = 2'd1;
            return 1'b0;
        end
        // too far from the previous period: drop it and start over
        if (!(diff < tenth))
        begin
            acq_count = 2'd0;
            return 1'b0;
        end
        sum_acc = sum_acc + SUM_W'(p);
        last_period = p;
        if (acq_count != LAST_COUNT)
        begin
            acq_count = acq_count + 2'd1;
            return 1'b0;
        end
        acq_count = 2'd0;
        avg_p = sum_acc[SUM_W-1:2];
        quot = (avg_p != 0) ? ref_hz_now / avg_p : '0;
        r.hundreds = HUND_W'(quot / FREQ_SPLIT);
        r.remainder = REM_W'(quot % FREQ_SPLIT);
        r.avg = avg_p;
        return 1'b1;
    endfunction

    // period generation
    function automatic int unsigned pick_base();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 15);
            1, 2:    return $urandom_range(10, 99);
            3, 4:    return $urandom_range(58000, 65535);
            default: return $urandom_range(100, 65535);
        endcase
    endfunction

    function automatic int unsigned nudge(input int unsigned p, input int unsigned d);
        bit up;
        up = $urandom_range(0, 1);
        if (up && p + d > 65535)
            up = 1'b0;
        if (!up && d > p)
            up = 1'b1;
        return up ? p + d : p - d;
    endfunction

    // mostly qualified runs of four, some broken runs, some unrelated values
    task automatic add_random_periods(input int unsigned n);
        int unsigned made;
        int unsigned kind;
        int unsigned p;
        int unsigned tenth;
        int unsigned d;
        int unsigned steps;
        int unsigned j;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(0, 9);
            p = (kind == 9) ? $urandom_range(0, 65535) : pick_base();
            period_backlog.push_back(p[PERIOD_W-1:0]);
            made++;
            if (kind < 7)
                steps = 3;
            else if (kind < 9)
                steps = $urandom_range(0, 2);
            else
                steps = 0;
            for (j = 0; j < steps; j++)
            begin
                tenth = p / 10;
                case ($urandom_range(0, 3))
                    0:       d = 0;
                    1:       d = (tenth == 0) ? 0 : tenth - 1;
                    default: d = (tenth == 0) ? 0 : $urandom_range(0, tenth - 1);
                endcase
                p = nudge(p, d);
                period_backlog.push_back(p[PERIOD_W-1:0]);
                made++;
            end
            if (kind == 9)
            begin
                // zero never qualifies after anything
                period_backlog.push_back('0);
                made++;
            end
            else if (kind >= 7)
            begin
                tenth = p / 10;
                d = ($urandom_range(0, 1) == 0) ? tenth : tenth + $urandom_range(0, tenth + 5);
                p = nudge(p, d);
                period_backlog.push_back(p[PERIOD_W-1:0]);
                made++;
            end
        end
    endtask

    task automatic load_directed();
        int unsigned j;
        // widest periods, sum past 16 bits
        for (j = 0; j < 4; j++)
            period_backlog.push_back(16'hFFFF);
        // smallest qualifying average
        for (j = 0; j < 4; j++)
            period_backlog.push_back(16'd10);
        // previous below ten never qualifies, also for zero
        period_backlog.push_back(16'd9);
        period_backlog.push_back(16'd9);
        period_backlog.push_back(16'd0);
        period_backlog.push_back(16'd0);
        // difference equal to the tenth fails
        period_backlog.push_back(16'd1000);
        period_backlog.push_back(16'd1100);
        // one below the tenth passes, alternating up and down
        period_backlog.push_back(16'd1000);
        period_backlog.push_back(16'd1099);
        period_backlog.push_back(16'd1000);
        period_backlog.push_back(16'd1099);
        // failure late in an acquisition
        period_backlog.push_back(16'd1000);
        period_backlog.push_back(16'd901);
        period_backlog.push_back(16'd1000);
        // alternating bit patterns
        period_backlog.push_back(16'h5555);
        period_backlog.push_back(16'h5556);
        period_backlog.push_back(16'h5554);
        period_backlog.push_back(16'h5555);
    endtask

    // wait for the input queue and the expected readings to empty, then settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (period_backlog.size() != 0 || in_valid || freq_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, called right after a rising edge
    task automatic write_ref_clock(input logic [REF_W-1:0] hz);
        cfg_valid <= 1'b1;
        cfg_ref_hz <= hz;
        do
            @(posedge clk);
        while (!cfg_ready);
        ref_hz_now = hz;
        cfg_valid <= 1'b0;
    endtask

    // period driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            // transaction taken: predict it
            if (in_valid && !in_stall)
            begin
                if (qualify_period(period_ticks, fresh_result))
                    freq_due.push_back(fresh_result);
                taken_total <= taken_total + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (period_backlog.size() != 0)
                begin
                    in_valid <= 1'b1;
                    period_ticks <= period_backlog.pop_front();
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started as the transaction count passes marks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (taken_total >= next_hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 320;
        end
    end

    // reading monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            pace <= PACE_FREE;
            pace_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (freq_due.size() == 0)
                    flag_mismatch($sformatf("unexpected reading, average %0d", average_period));
                else
                begin
                    oldest_due = freq_due.pop_front();
                    if (frequency_hundreds !== oldest_due.hundreds)
                        flag_mismatch($sformatf("hundreds %0d, want %0d",
                                                frequency_hundreds, oldest_due.hundreds));
                    if (frequency_remainder !== oldest_due.remainder)
                        flag_mismatch($sformatf("remainder %0d, want %0d",
                                                frequency_remainder, oldest_due.remainder));
                    if (average_period !== oldest_due.avg)
                        flag_mismatch($sformatf("average %0d, want %0d",
                                                average_period, oldest_due.avg));
                end
            end
            if (pace_left == 0)
            begin
                pace <= pace_t'($urandom_range(0, 3));
                pace_left <= $urandom_range(10, 150);
            end
            else
                pace_left <= pace_left - 1;
            case (pace)
                PACE_LIGHT:    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < 30);
                PACE_HEAVY:    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < 70);
                PACE_PERIODIC: out_stall <= (hold_left != 0) || (cyc[1:0] == 2'd0);
                default:       out_stall <= (hold_left != 0);
            endcase
        end
    end

    // phases: reset value with directed cases, then several register settings
    initial
    begin
        int unsigned ph;
        logic [REF_W-1:0] setting;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        load_directed();
        add_random_periods(RANDOM_PER_PHASE);
        wait_drained();
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       setting = '1;
                1:       setting = REF_W'(1);
                2:       setting = '0;
                3:       setting = REF_W'($urandom_range(1, 67108863));
                default: setting = REF_RESET_HZ;
            endcase
            write_ref_clock(setting);
            @(negedge clk);
            add_random_periods((ph == 2) ? 60 : RANDOM_PER_PHASE);
            wait_drained();
        end
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
